@@ sv/rie_pkg.sv @@
// Shared types and constants for the RTC interrupt emulator.
package rie_pkg;

  localparam int unsigned KernelHzDef    = 1000;
  localparam int unsigned MinPollRateDef = 64;

  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned FreqW   = 14;
  localparam int unsigned CpktW   = 32;
  localparam int unsigned AdvW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UPDATE_EN   = 3'd0,
    CFG_PERIODIC_EN = 3'd1,
    CFG_ALARM_EN    = 3'd2,
    CFG_ALARM_HOUR  = 3'd3,
    CFG_ALARM_MIN   = 3'd4,
    CFG_ALARM_SEC   = 3'd5,
    CFG_PER_FREQ    = 3'd6,
    CFG_CPKT        = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADV_GO,
    ST_ADV_RUN,
    ST_THR_GO,
    ST_THR_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic div_start;
    logic thr_pass;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ sv/rie_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
module rie_divider import rie_pkg::*; #(
  parameter int unsigned DVD_W  = 42,
  parameter int unsigned DVS_W  = FreqW,
  parameter int unsigned STEP_W = $clog2(DVD_W + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DVD_W-1:0]  quot_o
);

  logic [DVD_W-1:0]  q_q;
  logic [DVS_W-1:0]  r_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;

  logic [DVS_W:0] rs;
  logic           ge;

  assign rs = {r_q, q_q[DVD_W-1]};
  assign ge = rs >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops off cleanly
      r_q <= ge ? DVS_W'(rs - {1'b0, divisor_i}) : rs[DVS_W-1:0];
      q_q <= {q_q[DVD_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a preceding run");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

@@ sv/rie_datapath.sv @@
// Config registers, multiplier, shared divider, flag logic and result register.
module rie_datapath import rie_pkg::*; #(
  parameter int unsigned KERNEL_HZ     = KernelHzDef,
  parameter int unsigned MIN_POLL_RATE = MinPollRateDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [OutDataW-1:0] m_axis_tdata,
  input  ctrl_cmd_t           cmd_i,
  output ctrl_sts_t           sts_o
);

  localparam int unsigned HzW    = $clog2(KERNEL_HZ + 1);
  localparam int unsigned ProdW  = CpktW + HzW;
  localparam int unsigned StepW  = $clog2(ProdW + 1);
  localparam int unsigned CntW   = $clog2(MIN_POLL_RATE / 2 + 1);
  localparam logic [HzW-1:0]   HzC  = HzW'(KERNEL_HZ);
  localparam logic [FreqW-1:0] MinC = FreqW'(MIN_POLL_RATE);

  // configuration
  logic               upd_en_q, per_en_q, alm_en_q;
  logic [HourW-1:0]   alm_hour_q;
  logic [MinuteW-1:0] alm_min_q;
  logic [SecondW-1:0] alm_sec_q;
  logic [FreqW-1:0]   freq_q;
  logic [CpktW-1:0]   cpkt_q;

  // state and item registers
  logic [CntW-1:0]    per_cnt_q;
  logic [SecondW-1:0] last_sec_q;
  logic [HourW-1:0]   hour_q;
  logic [MinuteW-1:0] min_q;
  logic [SecondW-1:0] sec_q;
  logic [ProdW-1:0]   prod_q;
  logic [AdvW-1:0]    adv_q;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [FreqW-1:0] poll, fdiv;
  logic [ProdW-1:0] div_dvd, div_quot;
  logic [FreqW-1:0] div_dvs;
  logic [StepW-1:0] div_steps;
  logic             div_busy, div_done;
  logic [CntW:0]    cnt_inc;
  logic [FreqW-1:0] thr;
  logic             uf, pf, af, any_en;
  logic             cnt_clr;

  assign poll = (per_en_q && freq_q > MinC) ? freq_q : MinC;
  assign fdiv = (freq_q < FreqW'(2)) ? FreqW'(2) : freq_q;

  assign cnt_clr = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_PERIODIC_EN ||
                                cfg_reg_e'(cfg_idx_i) == CFG_PER_FREQ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_en_q   <= 1'b0;
      per_en_q   <= 1'b0;
      alm_en_q   <= 1'b0;
      alm_hour_q <= '0;
      alm_min_q  <= '0;
      alm_sec_q  <= '0;
      freq_q     <= FreqW'(64);
      cpkt_q     <= CpktW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_UPDATE_EN:   upd_en_q   <= cfg_data_i[0];
        CFG_PERIODIC_EN: per_en_q   <= cfg_data_i[0];
        CFG_ALARM_EN:    alm_en_q   <= cfg_data_i[0];
        CFG_ALARM_HOUR:  alm_hour_q <= cfg_data_i[HourW-1:0];
        CFG_ALARM_MIN:   alm_min_q  <= cfg_data_i[MinuteW-1:0];
        CFG_ALARM_SEC:   alm_sec_q  <= cfg_data_i[SecondW-1:0];
        CFG_PER_FREQ:    freq_q     <= cfg_data_i[FreqW-1:0];
        CFG_CPKT:        cpkt_q     <= cfg_data_i[CpktW-1:0];
      endcase
    end
  end

  // advance pass divides the product; threshold pass divides poll, left-aligned
  assign div_dvd   = cmd_i.thr_pass ? {poll, {(ProdW - FreqW){1'b0}}} : prod_q;
  assign div_dvs   = cmd_i.thr_pass ? fdiv : poll;
  assign div_steps = cmd_i.thr_pass ? StepW'(FreqW) : StepW'(ProdW);

  rie_divider #(
    .DVD_W (ProdW),
    .DVS_W (FreqW),
    .STEP_W(StepW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .steps_i   (div_steps),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      hour_q <= in_data_i[HourW-1:0];
      min_q  <= in_data_i[HourW+MinuteW-1:HourW];
      sec_q  <= in_data_i[HourW+MinuteW+SecondW-1:HourW+MinuteW];
    end
    if (cmd_i.mul_en) prod_q <= ProdW'(cpkt_q) * ProdW'(HzC);
    if (div_done && !cmd_i.thr_pass) adv_q <= div_quot[AdvW-1:0];
  end

  assign thr     = div_quot[FreqW-1:0];
  assign cnt_inc = {1'b0, per_cnt_q} + (CntW+1)'(1);
  assign any_en  = upd_en_q | per_en_q | alm_en_q;
  assign uf      = upd_en_q && (sec_q != last_sec_q);
  assign pf      = per_en_q && (FreqW'(cnt_inc) >= thr);
  assign af      = alm_en_q && sec_q == alm_sec_q && min_q == alm_min_q &&
                   hour_q == alm_hour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_cnt_q   <= '0;
      last_sec_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cnt_clr) begin
        per_cnt_q <= '0;
      end else if (cmd_i.finish && per_en_q) begin
        per_cnt_q <= pf ? '0 : cnt_inc[CntW-1:0];
      end
      if (cmd_i.finish && uf) last_sec_q <= sec_q;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {4'b0, (any_en ? adv_q : AdvW'(0)), (uf | pf | af), af, pf, uf};
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || m_axis_tready;

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || m_axis_tready))
    else $error("result overwritten before it was taken");

  a_cnt_clear_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && pf) |=> per_cnt_q == '0)
    else $error("periodic counter not cleared after firing");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    per_cnt_q <= CntW'(MIN_POLL_RATE / 2))
    else $error("periodic counter out of range");

  a_div_idle_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !div_busy)
    else $error("commit while the divider is still running");

endmodule

@@ sv/rie_ctrl.sv @@
// Sequencer: accepts a tick word, runs multiply and two divide passes, commits.
module rie_ctrl import rie_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_axis_tvalid) state_d = ST_MUL;
      ST_MUL:     state_d = ST_ADV_GO;
      ST_ADV_GO:  state_d = ST_ADV_RUN;
      ST_ADV_RUN: if (sts_i.div_done) state_d = ST_THR_GO;
      ST_THR_GO:  state_d = ST_THR_RUN;
      ST_THR_RUN: if (sts_i.div_done) state_d = ST_FINISH;
      ST_FINISH:  if (sts_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load_in = s_axis_tvalid;
      end
      ST_MUL:     cmd_o.mul_en = 1'b1;
      ST_ADV_GO:  cmd_o.div_start = 1'b1;
      ST_ADV_RUN: cmd_o.thr_pass = 1'b0;
      ST_THR_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.thr_pass  = 1'b1;
      end
      ST_THR_RUN: cmd_o.thr_pass = 1'b1;
      ST_FINISH: begin
        cmd_o.thr_pass = 1'b1;
        cmd_o.finish   = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  a_done_only_when_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_ADV_RUN || state_q == ST_THR_RUN))
    else $error("divider result arrived outside a divide pass");

endmodule

@@ sv/rtc_interrupt_emulator.sv @@
// Top level of the RTC interrupt emulator: sequencer plus datapath.
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  tick word: hour, minute, second
//  m_axis    out  m_axis_tvalid / m_axis_tready  flags, irq, compare advance
//  cfg       in   cfg_we_i                       register write, index and data
//
// A tick word runs a multiply and then the serial divider twice, where
// ProdW = 32 + clog2(KERNEL_HZ + 1): one pass of ProdW steps for the
// advance and one of 14 steps for the periodic threshold.
// Reset loads the register defaults and clears the periodic counter and the
// last second.
// A result waits in the output register; the next word is taken meanwhile
// and only the final commit stalls on m_axis_tready.
module rtc_interrupt_emulator import rie_pkg::*; #(
  parameter int unsigned KERNEL_HZ     = KernelHzDef,
  parameter int unsigned MIN_POLL_RATE = MinPollRateDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [4:0] current_hour, [10:5] current_minute, [16:11] current_second, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] update_flag, [1] periodic_flag, [2] alarm_flag, [3] irq_raised,
  // [35:4] compare_advance, zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rie_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  rie_datapath #(
    .KERNEL_HZ    (KERNEL_HZ),
    .MIN_POLL_RATE(MIN_POLL_RATE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .m_axis_tready(m_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata (m_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
